[hdl/m3i_pkg.sv]
// ============================================================================
// m3i_pkg
// Shared widths, types and latency figures for the 3x3 matrix inverse.
// ============================================================================
package m3i_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ORDER      = 3;

    localparam int PROD_W  = 2 * DATA_WIDTH;         // element x element
    localparam int COF_W   = PROD_W + 1;             // difference of two products
    localparam int PART_W  = 2 * DATA_WIDTH + 1;     // element x 33-bit cofactor slice
    localparam int DET_W   = 3 * DATA_WIDTH + 3;     // sum of three element x cofactor
    localparam int SHIFT   = 2 * FRAC_BITS;          // numerator scale
    localparam int NUM_W   = COF_W + SHIFT;          // scaled numerator magnitude
    localparam int HI_W    = NUM_W - DATA_WIDTH;     // numerator bits above the quotient
    localparam int CMP_W   = (HI_W > DET_W) ? HI_W : DET_W;
    localparam int REM_W   = DET_W + 1;              // trial remainder

    localparam int COF_LAT = 2;
    localparam int DET_LAT = 3;
    localparam int DIV_LAT = DATA_WIDTH + 3;
    localparam int LATENCY = COF_LAT + DET_LAT + DIV_LAT;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [COF_W-1:0]      cof_t;
    typedef logic signed [DET_W-1:0]      det_t;
    typedef elem_t mat_t [ORDER][ORDER];
    typedef cof_t  cof_mat_t [ORDER][ORDER];

    typedef struct packed {
        logic  singular;
        elem_t quo;
    } div_res_t;

endpackage

[hdl/m3i_cofactor.sv]
// ============================================================================
// m3i_cofactor
// Two-stage cofactor array: products, then differences. Passes the matrix on.
// ============================================================================
module m3i_cofactor
    import m3i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  mat_t     m,
    output logic     out_valid,
    output cof_mat_t cof,
    output mat_t     m_out
);

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pa_reg [ORDER][ORDER];
    logic signed [PROD_W-1:0] pb_reg [ORDER][ORDER];
    cof_t                     cof_reg [ORDER][ORDER];
    mat_t                     m1_reg;
    mat_t                     m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    for (genvar c = 0; c < ORDER; c++)
    begin : g_c
        for (genvar r = 0; r < ORDER; r++)
        begin : g_r
            localparam int C1 = (c + 1) % ORDER;
            localparam int C2 = (c + 2) % ORDER;
            localparam int R1 = (r + 1) % ORDER;
            localparam int R2 = (r + 2) % ORDER;

            always_ff @(posedge clk)
            begin
                pa_reg[c][r]  <= PROD_W'(m[C1][R1]) * PROD_W'(m[C2][R2]);
                pb_reg[c][r]  <= PROD_W'(m[C2][R1]) * PROD_W'(m[C1][R2]);
                cof_reg[c][r] <= COF_W'(pa_reg[c][r]) - COF_W'(pb_reg[c][r]);
                m1_reg[c][r]  <= m[c][r];
                m2_reg[c][r]  <= m1_reg[c][r];
            end
        end
    end

    assign out_valid = v2_reg;
    assign cof       = cof_reg;
    assign m_out     = m2_reg;

endmodule

[hdl/m3i_det.sv]
// ============================================================================
// m3i_det
// Three-stage determinant: split products, recombine, sum along row 0.
// ============================================================================
module m3i_det
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  elem_t row0 [ORDER],
    input  cof_t  cof0 [ORDER],
    output logic  out_valid,
    output det_t  det
);

    logic                     va_reg;
    logic                     vb_reg;
    logic                     vc_reg;
    logic signed [PART_W-1:0] plo_reg [ORDER];
    logic signed [PART_W-1:0] phi_reg [ORDER];
    det_t                     prod_reg [ORDER];
    det_t                     det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    for (genvar c = 0; c < ORDER; c++)
    begin : g_c
        logic signed [DATA_WIDTH:0] lo_w;
        logic signed [DATA_WIDTH:0] hi_w;

        assign lo_w = signed'({1'b0, cof0[c][DATA_WIDTH-1:0]});
        assign hi_w = cof0[c][COF_W-1:DATA_WIDTH];

        always_ff @(posedge clk)
        begin
            plo_reg[c]  <= PART_W'(row0[c]) * PART_W'(lo_w);
            phi_reg[c]  <= PART_W'(row0[c]) * PART_W'(hi_w);
            prod_reg[c] <= (DET_W'(phi_reg[c]) <<< DATA_WIDTH) + DET_W'(plo_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
    end

    assign out_valid = vc_reg;
    assign det       = det_reg;

endmodule

[hdl/m3i_div.sv]
// ============================================================================
// m3i_div
// Pipelined signed divider, one quotient bit per stage, saturating result.
// ============================================================================
module m3i_div
    import m3i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  cof_t     num,
    input  det_t     den,
    output logic     out_valid,
    output div_res_t res
);

    // magnitude stage
    logic               v0_reg;
    logic               neg0_reg;
    logic               zero0_reg;
    logic [COF_W-1:0]   nmag0_reg;
    logic [DET_W-1:0]   dmag0_reg;

    // bit stages, index 0 is the range check
    logic                  v_reg    [DATA_WIDTH+1];
    logic                  neg_reg  [DATA_WIDTH+1];
    logic                  zero_reg [DATA_WIDTH+1];
    logic                  big_reg  [DATA_WIDTH+1];
    logic [DET_W-1:0]      p_reg    [DATA_WIDTH+1];
    logic [DET_W-1:0]      dmag_reg [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] low_reg  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] q_reg    [DATA_WIDTH+1];

    logic [NUM_W-1:0] nfull;
    logic [HI_W-1:0]  hi;
    logic             big;

    logic     out_valid_reg;
    div_res_t res_reg;
    div_res_t res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v_reg[0]      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg        <= in_valid;
            v_reg[0]      <= v0_reg;
            out_valid_reg <= v_reg[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        neg0_reg  <= num[COF_W-1] ^ den[DET_W-1];
        zero0_reg <= (den == '0);
        nmag0_reg <= num[COF_W-1] ? COF_W'(-num) : COF_W'(num);
        dmag0_reg <= den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
    end

    // quotient overflows the data width when the upper numerator reaches |det|
    always_comb
    begin
        nfull = {nmag0_reg, {SHIFT{1'b0}}};
        hi    = nfull[NUM_W-1:DATA_WIDTH];
        big   = CMP_W'(hi) >= CMP_W'(dmag0_reg);
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= neg0_reg;
        zero_reg[0] <= zero0_reg;
        big_reg[0]  <= big;
        p_reg[0]    <= DET_W'(hi);
        dmag_reg[0] <= dmag0_reg;
        low_reg[0]  <= nfull[DATA_WIDTH-1:0];
        q_reg[0]    <= '0;
    end

    for (genvar k = 1; k <= DATA_WIDTH; k++)
    begin : g_bit
        logic [REM_W-1:0] t_w;
        logic             ge_w;

        assign t_w  = {p_reg[k-1], low_reg[k-1][DATA_WIDTH-k]};
        assign ge_w = t_w >= {1'b0, dmag_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            p_reg[k]    <= ge_w ? DET_W'(t_w - {1'b0, dmag_reg[k-1]}) : DET_W'(t_w);
            q_reg[k]    <= {q_reg[k-1][DATA_WIDTH-2:0], ge_w};
            neg_reg[k]  <= neg_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            big_reg[k]  <= big_reg[k-1];
            dmag_reg[k] <= dmag_reg[k-1];
            low_reg[k]  <= low_reg[k-1];
        end
    end

    always_comb
    begin
        logic [DATA_WIDTH-1:0] mag;
        logic [DATA_WIDTH-1:0] lim;
        mag = q_reg[DATA_WIDTH];
        lim = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        res_next.singular = 1'b0;
        if (zero_reg[DATA_WIDTH])
        begin
            res_next.singular = 1'b1;
            res_next.quo      = '0;
        end
        else if (neg_reg[DATA_WIDTH])
        begin
            res_next.quo = (big_reg[DATA_WIDTH] || mag > lim) ? elem_t'(lim)
                                                              : elem_t'(-mag);
        end
        else
        begin
            res_next.quo = (big_reg[DATA_WIDTH] || mag >= lim) ? elem_t'(~lim)
                                                               : elem_t'(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[hdl/matrix3x3_inverse.sv]
// ============================================================================
// matrix3x3_inverse
// Fully pipelined 3x3 inverse in Q16.16: adjugate over determinant.
// ============================================================================
// Usage:
//   A request is taken on every rising edge where start is high and busy is
//   low. busy stays low, so a new matrix may enter in every cycle.
//   e_cC_rR is the element at column C, row R (signed Q16.16).
//   The inverse appears on v_cC_rR together with singular, for exactly one
//   cycle, marked by done. There is no back-pressure: the receiver must take
//   each result in the cycle done is high.
//   Each request passes the cofactor array, the determinant and the
//   bit-per-stage dividers in turn. Throughput: one matrix per cycle.
//   Quotients truncate toward zero and saturate to the Q16.16 range.
//   A zero determinant gives all-zero outputs with singular high.
//   Reset clears every valid bit; nothing in flight survives it.
// ============================================================================
module matrix3x3_inverse
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  elem_t e_c0_r0,
    input  elem_t e_c0_r1,
    input  elem_t e_c0_r2,
    input  elem_t e_c1_r0,
    input  elem_t e_c1_r1,
    input  elem_t e_c1_r2,
    input  elem_t e_c2_r0,
    input  elem_t e_c2_r1,
    input  elem_t e_c2_r2,
    output logic  done,
    output elem_t v_c0_r0,
    output elem_t v_c0_r1,
    output elem_t v_c0_r2,
    output elem_t v_c1_r0,
    output elem_t v_c1_r1,
    output elem_t v_c1_r2,
    output elem_t v_c2_r0,
    output elem_t v_c2_r1,
    output elem_t v_c2_r2,
    output logic  singular
);

    mat_t     in_m;
    mat_t     cf_m;
    cof_mat_t cf_cof;
    logic     cf_valid;
    elem_t    row0 [ORDER];
    cof_t     cof0 [ORDER];
    logic     det_valid;
    det_t     det;

    // cofactors wait here while the determinant is formed
    cof_mat_t cd_reg [DET_LAT];

    logic     dv_valid [ORDER][ORDER];
    div_res_t dv_res   [ORDER][ORDER];

    // always ready: the pipeline never stalls
    assign busy = 1'b0;

    assign in_m[0][0] = e_c0_r0;
    assign in_m[0][1] = e_c0_r1;
    assign in_m[0][2] = e_c0_r2;
    assign in_m[1][0] = e_c1_r0;
    assign in_m[1][1] = e_c1_r1;
    assign in_m[1][2] = e_c1_r2;
    assign in_m[2][0] = e_c2_r0;
    assign in_m[2][1] = e_c2_r1;
    assign in_m[2][2] = e_c2_r2;

    m3i_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .m         (in_m),
        .out_valid (cf_valid),
        .cof       (cf_cof),
        .m_out     (cf_m)
    );

    for (genvar c = 0; c < ORDER; c++)
    begin : g_row0
        assign row0[c] = cf_m[c][0];
        assign cof0[c] = cf_cof[c][0];
    end

    // det = sum over columns of m(c,0) * cof(c,0)
    m3i_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cf_valid),
        .row0      (row0),
        .cof0      (cof0),
        .out_valid (det_valid),
        .det       (det)
    );

    always_ff @(posedge clk)
    begin
        cd_reg[0] <= cf_cof;
        for (int s = 1; s < DET_LAT; s++)
        begin
            cd_reg[s] <= cd_reg[s-1];
        end
    end

    // output (column c, row r) is cof(r,c) / det
    for (genvar c = 0; c < ORDER; c++)
    begin : g_dc
        for (genvar r = 0; r < ORDER; r++)
        begin : g_dr
            m3i_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (det_valid),
                .num       (cd_reg[DET_LAT-1][r][c]),
                .den       (det),
                .out_valid (dv_valid[c][r]),
                .res       (dv_res[c][r])
            );
        end
    end

    // all nine dividers run in lockstep
    assign done     = dv_valid[0][0];
    assign singular = dv_res[0][0].singular;

    assign v_c0_r0 = dv_res[0][0].quo;
    assign v_c0_r1 = dv_res[0][1].quo;
    assign v_c0_r2 = dv_res[0][2].quo;
    assign v_c1_r0 = dv_res[1][0].quo;
    assign v_c1_r1 = dv_res[1][1].quo;
    assign v_c1_r2 = dv_res[1][2].quo;
    assign v_c2_r0 = dv_res[2][0].quo;
    assign v_c2_r1 = dv_res[2][1].quo;
    assign v_c2_r2 = dv_res[2][2].quo;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete after LATENCY cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done without a matching request");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (v_c0_r0 == '0 && v_c0_r1 == '0 && v_c0_r2 == '0 &&
                                v_c1_r0 == '0 && v_c1_r1 == '0 && v_c1_r2 == '0 &&
                                v_c2_r0 == '0 && v_c2_r1 == '0 && v_c2_r2 == '0))
        else $error("singular result with nonzero elements");

    a_zero_row: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && e_c0_r0 == '0 && e_c1_r0 == '0 && e_c2_r0 == '0)
            |-> ##LATENCY (done && singular))
        else $error("zero row not flagged singular");
`endif

endmodule
